// ===== src/piecewise_power_law_rate_defines.svh =====
`ifndef PIECEWISE_POWER_LAW_RATE_DEFINES_SVH
`define PIECEWISE_POWER_LAW_RATE_DEFINES_SVH

// same-cycle implication, reset masked
`define PPLR_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pplr check failed");

// next-cycle implication, reset masked
`define PPLR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pplr check failed");

`endif

// ===== src/pplr_pkg.sv =====
`default_nettype none
package pplr_pkg;

  localparam int MAX_SEGMENTS = 8;
  localparam int SEG_AW = $clog2(MAX_SEGMENTS);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic CFG_PRESSURE_SCALE  = 1'b0;
  localparam logic CFG_SEGMENTS_IN_USE = 1'b1;

  localparam logic [31:0] SCALE_RESET = 32'h0001_0000;
  localparam logic [3:0]  SEGS_RESET  = 4'd1;
  localparam logic [47:0] RATE_MAX    = {48{1'b1}};

  typedef struct packed {
    logic               command;
    logic [2:0]         entry_index;
    logic [31:0]        bound_value;
    logic [31:0]        coefficient;
    logic signed [15:0] power_exponent;
    logic [31:0]        pressure;
  } in_word_t;

  typedef struct packed {
    logic [47:0] rate;
    logic [2:0]  segment_used;
    logic        saturated;
  } out_word_t;

  typedef struct packed {
    logic [31:0] bound;
    logic [31:0] coeff;
    logic [15:0] expo;
  } seg_entry_t;

  localparam int ENTRY_W = $bits(seg_entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_FETCH,
    ST_LOG,
    ST_YMUL,
    ST_EXP_START,
    ST_EXP_WAIT,
    ST_CMUL,
    ST_SHIFT
  } state_t;

endpackage
`default_nettype wire

// ===== src/pplr_ram.sv =====
`default_nettype none
module pplr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/pplr_sqrt.sv =====
`default_nettype none
module pplr_sqrt import pplr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] operand,
  output logic             done,
  output logic [31:0]      root
);

  // one result bit per cycle, restoring method
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [63:0] v_r, v_nxt;
  logic [35:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  always_comb begin
    rem_sh   = {rem_r[33:0], v_r[63:62]};
    trial    = {2'b00, root_r, 2'b01};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    v_nxt    = v_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd31;
      v_nxt    = operand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      v_nxt = {v_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    v_r    <= v_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

// ===== src/piecewise_power_law_rate.sv =====
// load word: no result; the entry is written to the segment ram
// evaluate word: scan of segments_in_use entries (held to 1..8), log2, exp2, then the result
// (log2 and exp2 skipped when the base or the coefficient is zero); the result can be stalled
// exp2 takes 16 steps, each a bit-serial square root
// one word in flight; next word taken as soon as the result sits in the output register
// sync active-low reset: scale 1.0, one segment, ram contents undefined until loaded
`default_nettype none
`include "piecewise_power_law_rate_defines.svh"
module piecewise_power_law_rate import pplr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_index,
  input  wire logic [31:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [31:0] scale_r;
  logic [3:0]  segs_r;
  logic [SEG_AW-1:0] used_m1;

  logic        in_acc;
  logic        ram_we;
  logic [SEG_AW-1:0] ram_raddr;
  seg_entry_t  ram_wdata, ram_rdata;

  logic [31:0] press_r;
  logic [63:0] bprod_r;
  logic [31:0] base_r;
  logic [SEG_AW-1:0] k_r;
  logic [SEG_AW:0]   cnt_r;
  logic [SEG_AW-1:0] seg_r;
  logic [31:0] coeff_r;
  logic signed [15:0] expo_r;
  logic        sat_r;
  logic        zero_r;
  logic [4:0]  msb_r;
  logic [31:0] m_r;
  logic [15:0] frac_r;
  logic [3:0]  it_r;
  logic signed [24:0] y_r;
  logic [31:0] r_r;
  logic [63:0] prod_r;
  logic        out_valid_r;
  out_word_t   out_r;

  logic        sqrt_start, sqrt_done;
  logic [31:0] sqrt_root;
  logic [63:0] sqrt_op;

  logic [4:0]  msb_c;
  logic [63:0] msq;
  logic [32:0] sq;
  logic signed [20:0] lg;
  logic signed [36:0] yfull;
  logic signed [8:0]  n_c;
  logic [15:0] f_c;
  logic signed [9:0]  s_c;
  logic [9:0]  sh_c;
  logic [63:0] lsh, rsh;
  logic [47:0] rate_c;
  logic        sat_c;
  logic        out_free;
  logic [SEG_AW:0] cnt_inc;

  assign used_m1 = (segs_r == 4'd0) ? '0 :
                   (segs_r > 4'(MAX_SEGMENTS)) ? SEG_AW'(MAX_SEGMENTS - 1) :
                   SEG_AW'(segs_r - 4'd1);

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
      segs_r  <= SEGS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PRESSURE_SCALE:  scale_r <= cfg_data;
        CFG_SEGMENTS_IN_USE: segs_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign ram_wdata = '{bound: in_word.bound_value, coeff: in_word.coefficient,
                       expo: in_word.power_exponent};

  pplr_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SEGMENTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_word.entry_index[SEG_AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // r stays below 2^31, so the shifted value fits 32 bits
  assign sqrt_op = {2'b00, r_r << f_c[it_r], 30'b0};

  pplr_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sqrt_start),
    .operand (sqrt_op),
    .done    (sqrt_done),
    .root    (sqrt_root)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_word.command == CMD_EVAL) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN:      if (k_r == used_m1) state_nxt = ST_PICK;
      ST_PICK:      state_nxt = ST_FETCH;
      ST_FETCH: begin
        if (base_r == 32'd0 || ram_rdata.coeff == 32'd0) begin
          state_nxt = ST_SHIFT;
        end else begin
          state_nxt = ST_LOG;
        end
      end
      ST_LOG:       if (it_r == 4'd15) state_nxt = ST_YMUL;
      ST_YMUL:      state_nxt = ST_EXP_START;
      ST_EXP_START: state_nxt = ST_EXP_WAIT;
      ST_EXP_WAIT: begin
        if (sqrt_done) begin
          state_nxt = (it_r == 4'd15) ? ST_CMUL : ST_EXP_START;
        end
      end
      ST_CMUL:      state_nxt = ST_SHIFT;
      ST_SHIFT:     if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall   = 1'b1;
    ram_we     = 1'b0;
    ram_raddr  = '0;
    sqrt_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        ram_we   = in_valid && in_word.command == CMD_LOAD;
      end
      ST_SCAN:      ram_raddr = k_r + SEG_AW'(1);
      ST_PICK:      ram_raddr = seg_r;
      ST_EXP_START: sqrt_start = 1'b1;
      default: ;
    endcase
  end

  // log2 helpers
  always_comb begin
    msb_c = '0;
    for (int i = 0; i < 32; i++) begin
      if (base_r[i]) msb_c = 5'(i);
    end
  end

  assign msq   = 64'(m_r) * 64'(m_r);
  assign sq    = msq[63:31];
  assign lg    = signed'({msb_r ^ 5'h10, frac_r});
  assign yfull = 37'(expo_r) * 37'(lg);
  assign n_c   = y_r[24:16];
  assign f_c   = y_r[15:0];
  assign s_c   = 10'(n_c) - 10'sd30;
  assign sh_c  = 10'(-s_c);
  assign lsh   = prod_r << s_c[5:0];
  assign rsh   = prod_r >> sh_c[5:0];
  assign cnt_inc = (ram_rdata.bound < press_r) ? cnt_r + 1'b1 : cnt_r;

  // final scaling by 2^(n-30)
  always_comb begin
    rate_c = '0;
    sat_c  = sat_r;
    if (!zero_r) begin
      if (s_c >= 0) begin
        if (s_c >= 10'sd48 || (prod_r >> (6'd48 - s_c[5:0])) != 64'd0) begin
          rate_c = RATE_MAX;
          sat_c  = 1'b1;
        end else begin
          rate_c = lsh[47:0];
        end
      end else if (sh_c < 10'd64) begin
        if (rsh[63:48] != 16'd0) begin
          rate_c = RATE_MAX;
          sat_c  = 1'b1;
        end else begin
          rate_c = rsh[47:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SHIFT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        press_r <= in_word.pressure;
        bprod_r <= 64'(in_word.pressure) * 64'(scale_r);
        k_r     <= '0;
        cnt_r   <= '0;
      end
      ST_SCAN: begin
        cnt_r <= cnt_inc;
        k_r   <= k_r + SEG_AW'(1);
        seg_r <= ((SEG_AW+1)'(used_m1) < cnt_inc) ? used_m1 : cnt_inc[SEG_AW-1:0];
      end
      ST_PICK: begin
        if (bprod_r[63:48] != 16'd0) begin
          base_r <= 32'hFFFF_FFFF;
          sat_r  <= 1'b1;
        end else begin
          base_r <= bprod_r[47:16];
          sat_r  <= 1'b0;
        end
      end
      ST_FETCH: begin
        coeff_r <= ram_rdata.coeff;
        expo_r  <= signed'(ram_rdata.expo);
        zero_r  <= base_r == 32'd0 || ram_rdata.coeff == 32'd0;
        if (base_r == 32'd0) sat_r <= 1'b0;
        msb_r   <= msb_c;
        m_r     <= base_r << (5'd31 - msb_c);
        it_r    <= '0;
      end
      ST_LOG: begin
        frac_r <= {frac_r[14:0], sq[32]};
        m_r    <= sq[32] ? sq[32:1] : sq[31:0];
        it_r   <= it_r + 4'd1;
      end
      ST_YMUL: begin
        y_r  <= yfull[36:12];
        r_r  <= 32'h4000_0000;
        it_r <= '0;
      end
      ST_EXP_WAIT: begin
        if (sqrt_done) begin
          r_r  <= sqrt_root;
          it_r <= it_r + 4'd1;
        end
      end
      ST_CMUL: prod_r <= 64'(coeff_r) * 64'(r_r);
      ST_SHIFT: begin
        if (out_free) begin
          out_r.rate         <= rate_c;
          out_r.segment_used <= 3'(seg_r);
          out_r.saturated    <= sat_c;
        end
      end
      default: ;
    endcase
    if (state_r == ST_IDLE) frac_r <= '0;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  `PPLR_ASSERT_NOW(a_sqrt_only_waited, sqrt_done, state_r == ST_EXP_WAIT)
  `PPLR_ASSERT_NEXT(a_hold_result, state_r == ST_SHIFT && out_valid_r && out_stall,
                    state_r == ST_SHIFT && out_valid_r)
  `PPLR_ASSERT_NOW(a_scan_in_range, state_r == ST_SCAN, k_r <= used_m1)
  `PPLR_ASSERT_NEXT(a_load_no_result, in_acc && in_word.command == CMD_LOAD && !out_valid_r,
                    !out_valid_r)

endmodule
`default_nettype wire

// ===== verif/piecewise_power_law_rate_tb.sv =====
`default_nettype none
module piecewise_power_law_rate_tb;
  import pplr_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_PRESSURE_SCALE;
  logic [31:0] cfg_data = '0;

  piecewise_power_law_rate dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the block state
  logic [31:0]        scale_reg = SCALE_RESET;
  logic [3:0]         seg_count = SEGS_RESET;
  logic [31:0]        bound_tab [MAX_SEGMENTS];
  logic [31:0]        coeff_tab [MAX_SEGMENTS];
  logic signed [15:0] expo_tab [MAX_SEGMENTS];

  in_word_t  pending_q[$];
  out_word_t rate_q[$];
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        mismatches = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2 of a nonzero Q16.16 value, signed Q16.16
  function automatic longint log2_fix(logic [31:0] base);
    int          msb;
    logic [63:0] m;
    logic [63:0] sq;
    logic [15:0] frac;
    msb = 31;
    while (!base[msb]) msb--;
    m = {32'b0, base} << (31 - msb);
    frac = '0;
    for (int k = 0; k < 16; k++) begin
      sq = (m * m) >> 31;
      frac = {frac[14:0], 1'b0};
      if (sq >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        m = sq >> 1;
      end else begin
        m = sq;
      end
    end
    return longint'((msb - 16) * 65536) + longint'(frac);
  endfunction

  // 2^(f/2^16) as Q2.30
  function automatic logic [63:0] exp2_fix(logic [15:0] f);
    logic [63:0] r;
    logic [63:0] t;
    r = 64'd1 << 30;
    for (int k = 0; k < 16; k++) begin
      t = r << f[k];
      r = int_sqrt(t << 30);
    end
    return r;
  endfunction

  function automatic out_word_t predict_rate(logic [31:0] press);
    int          used;
    int          cnt;
    int          seg;
    logic [63:0] prod;
    logic [63:0] rate;
    longint      expo;
    longint      y;
    longint      n;
    longint      s;
    logic        sat;
    out_word_t   o;
    used = seg_count;
    if (used < 1) used = 1;
    if (used > MAX_SEGMENTS) used = MAX_SEGMENTS;
    cnt = 0;
    for (int k = 0; k < used; k++)
      if (bound_tab[k] < press) cnt++;
    seg = (cnt < used - 1) ? cnt : used - 1;
    prod = (64'(press) * 64'(scale_reg)) >> 16;
    sat = 1'b0;
    if (prod > 64'hFFFF_FFFF) begin
      prod = 64'hFFFF_FFFF;
      sat = 1'b1;
    end
    rate = '0;
    if (prod == 0) begin
      sat = 1'b0;
    end else if (coeff_tab[seg] != 0) begin
      expo = expo_tab[seg];
      y = (expo * log2_fix(prod[31:0])) >>> 12;
      n = y >>> 16;
      prod = 64'(coeff_tab[seg]) * exp2_fix(y[15:0]);
      s = n - 30;
      if (s >= 0) begin
        if (s >= 48 || prod > (64'(RATE_MAX) >> s)) begin
          rate = 64'(RATE_MAX);
          sat = 1'b1;
        end else begin
          rate = prod << s;
        end
      end else begin
        rate = (-s >= 64) ? 64'd0 : prod >> (-s);
        if (rate > 64'(RATE_MAX)) begin
          rate = 64'(RATE_MAX);
          sat = 1'b1;
        end
      end
    end
    o.rate = rate[47:0];
    o.segment_used = seg[2:0];
    o.saturated = sat;
    return o;
  endfunction

  function automatic in_word_t load_word(logic [2:0] idx, logic [31:0] bound,
                                         logic [31:0] coeff, logic [15:0] expo);
    in_word_t w;
    w.command = CMD_LOAD;
    w.entry_index = idx;
    w.bound_value = bound;
    w.coefficient = coeff;
    w.power_exponent = expo;
    w.pressure = $urandom;
    return w;
  endfunction

  function automatic in_word_t eval_word(logic [31:0] press);
    in_word_t w;
    w.command = CMD_EVAL;
    w.entry_index = 3'($urandom);
    w.bound_value = $urandom;
    w.coefficient = $urandom;
    w.power_exponent = 16'($urandom);
    w.pressure = press;
    return w;
  endfunction

  function automatic in_word_t random_word();
    logic [2:0]  idx;
    logic [31:0] v;
    logic [31:0] c;
    logic [15:0] e;
    idx = 3'($urandom_range(7));
    if ($urandom_range(99) < 30) begin
      // mostly ascending bounds so every segment gets reached
      if ($urandom_range(9) == 0) v = $urandom;
      else v = {idx, 29'($urandom)};
      case ($urandom_range(5))
        0: c = '0;
        1: c = 32'hFFFF_FFFF;
        2: c = 32'h0001_0000;
        default: c = $urandom >> $urandom_range(31);
      endcase
      case ($urandom_range(5))
        0: e = 16'($urandom);
        1: e = ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
        default: e = 16'($urandom_range(16383)) - 16'd8192;
      endcase
      return load_word(idx, v, c, e);
    end
    case ($urandom_range(9))
      0: v = '0;
      1, 2, 3: v = bound_tab[idx] + 32'($signed($urandom_range(2)) - 1);
      4: v = 32'hFFFF_FFFF;
      default: v = $urandom >> $urandom_range(31);
    endcase
    return eval_word(v);
  endfunction

  // driver
  always @(posedge clk) begin : drive_blk
    logic hold;
    hold = in_valid && in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_word_t w;
        w = pending_q.pop_front();
        if (w.command == CMD_EVAL) begin
          rate_q.push_back(predict_rate(w.pressure));
        end else if (w.entry_index < MAX_SEGMENTS) begin
          bound_tab[w.entry_index] = w.bound_value;
          coeff_tab[w.entry_index] = w.coefficient;
          expo_tab[w.entry_index] = w.power_exponent;
        end
      end
      if (!hold) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_word <= pending_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch_blk
    out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rate_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: rate %h seg %0d sat %b",
                     out_word.rate, out_word.segment_used, out_word.saturated);
        end else begin
          want = rate_q.pop_front();
          if (want !== out_word) begin
            mismatches++;
            if (mismatches <= 10)
              $display("rate mismatch: exp rate %h seg %0d sat %b, got rate %h seg %0d sat %b",
                       want.rate, want.segment_used, want.saturated,
                       out_word.rate, out_word.segment_used, out_word.saturated);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic cfg_write(logic idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PRESSURE_SCALE) scale_reg = data;
    else seg_count = data[3:0];
    @(posedge clk);
  endtask

  task automatic drain();
    do @(posedge clk); while (pending_q.size() != 0 || in_valid || rate_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  initial begin : stim_blk
    logic [31:0] scales [8];
    logic [3:0]  counts [8];
    scales = '{32'h0001_0000, 32'h0, 32'hFFFF_FFFF, 32'h0000_8000,
               $urandom, 32'h0000_0010, 32'h0010_0000, $urandom};
    counts = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd4, 4'd8, 4'd3, 4'd2};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every entry loaded before any evaluate reads it
    pending_q.push_back(load_word(3'd0, 32'h0,         32'h0001_0000, 16'h1000));
    pending_q.push_back(load_word(3'd1, 32'h0001_0000, 32'hFFFF_FFFF, 16'h7FFF));
    pending_q.push_back(load_word(3'd2, 32'h0008_0000, 32'h0,         16'h0000));
    pending_q.push_back(load_word(3'd3, 32'h0010_0000, 32'h0000_8000, 16'h8000));
    pending_q.push_back(load_word(3'd4, 32'h0100_0000, 32'h1,         16'hF000));
    pending_q.push_back(load_word(3'd5, 32'h1000_0000, 32'h1234_5678, 16'h2000));
    pending_q.push_back(load_word(3'd6, 32'h8000_0000, 32'h0001_0000, 16'h0800));
    pending_q.push_back(load_word(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    pending_q.push_back(eval_word(32'h0));
    pending_q.push_back(eval_word(32'hFFFF_FFFF));
    pending_q.push_back(eval_word(32'h0000_0001));
    drain();
    cfg_write(CFG_SEGMENTS_IN_USE, 32'd8);
    foreach (bound_tab[k]) begin
      pending_q.push_back(eval_word(bound_tab[k]));
      pending_q.push_back(eval_word(bound_tab[k] + 32'd1));
    end
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      cfg_write(CFG_PRESSURE_SCALE, scales[p]);
      cfg_write(CFG_SEGMENTS_IN_USE, 32'(counts[p]));
      repeat (225) pending_q.push_back(random_word());
      drain();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
